@@ design/p2ac_pkg.sv @@
// Shared types and constants for the 2x2 average pooling classifier.
// No dependencies; imported by every design file of the block but p2ac_ram.
package p2ac_pkg;

  // Configuration register layout
  localparam int SIZE_W      = 9;    // out_cols / out_rows
  localparam int THR_W       = 14;   // Q2 thresholds
  localparam int CFG_DATA_W  = 14;   // widest register
  localparam int CFG_INDEX_W = 2;

  localparam int MAX_OUT_ROWS = 256;
  localparam int ROW_W        = 9;   // sample row inside a frame, < 2*MAX_OUT_ROWS

  localparam logic [SIZE_W-1:0] OUT_COLS_RST = 9'd5;
  localparam logic [SIZE_W-1:0] OUT_ROWS_RST = 9'd5;
  localparam logic [THR_W-1:0]  HIGH_THR_RST = 14'd260;
  localparam logic [THR_W-1:0]  CRIT_THR_RST = 14'd340;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OUT_COLS = 2'd0,
    REG_OUT_ROWS = 2'd1,
    REG_HIGH_THR = 2'd2,
    REG_CRIT_THR = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LEVEL_NORMAL   = 2'd0,
    LEVEL_HIGH     = 2'd1,
    LEVEL_CRITICAL = 2'd2
  } level_t;

  // Block position and frame flag that travel with a pair sum
  typedef struct packed {
    logic       last;
    logic [7:0] col;
    logic [7:0] row;
  } stage_t;

endpackage

@@ design/pool_2x2_average_classify.sv @@
// Top level of the 2x2 average pooling classifier.
// Uses p2ac_pkg, p2ac_front, p2ac_ram and p2ac_back.
//
// Usage:
//  - Input channel: sample (signed, whole degrees) and frame_start, in raster
//    order, with sample_valid / sample_stall. A request is taken at a clock
//    edge with sample_valid high and sample_stall low. frame_start puts the
//    position back to row 0, column 0 for that sample.
//  - Result channel: average_q2 (sum of the four samples = Q2 average),
//    level_class (0 normal, 1 high, 2 critical), block_col, block_row and
//    last_of_frame, with result_valid / result_stall. One result per 2x2
//    block, produced by the bottom-right sample of the block.
//  - Configuration: cfg_we / cfg_index / cfg_data write out_cols, out_rows
//    and the two Q2 thresholds; write only while the block is idle.
//  - Path: the request that finishes a block loads the stage register, whose
//    contents then pass through classify into the result register. Throughput:
//    one sample per cycle while sample_stall is low.
//  - The line buffer (one pair sum per output column) is a RAM with one
//    write and one registered read port; the read port carries the upper
//    pair sum into the second stage.
//  - Stall: a stage register and the result register act as a skid pair;
//    sample_stall rises only while both are full and result_stall is high.
//  - Reset: position, partial sum and valid flags clear, registers return to
//    5 x 5 blocks with thresholds 260 and 340. Line buffer is not cleared.
module pool_2x2_average_classify #(
  parameter int MAX_OUT_COLS = 256,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [p2ac_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [p2ac_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                frame_start,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS+1:0]       average_q2,
  output logic [1:0]                          level_class,
  output logic [7:0]                          block_col,
  output logic [7:0]                          block_row,
  output logic                                last_of_frame
);
  import p2ac_pkg::*;

  localparam int CLAMP_COLS = (MAX_OUT_COLS < 511) ? MAX_OUT_COLS : 511;
  localparam int ADDR_W     = (CLAMP_COLS > 1) ? $clog2(CLAMP_COLS) : 1;
  localparam int PAIR_W     = SAMPLE_BITS + 1;

  // configuration registers
  logic [SIZE_W-1:0]       out_cols;
  logic [SIZE_W-1:0]       out_rows;
  logic signed [THR_W-1:0] high_thr;
  logic signed [THR_W-1:0] crit_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cols <= OUT_COLS_RST;
      out_rows <= OUT_ROWS_RST;
      high_thr <= HIGH_THR_RST;
      crit_thr <= CRIT_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OUT_COLS: out_cols <= cfg_data[SIZE_W-1:0];
        REG_OUT_ROWS: out_rows <= cfg_data[SIZE_W-1:0];
        REG_HIGH_THR: high_thr <= cfg_data[THR_W-1:0];
        REG_CRIT_THR: crit_thr <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake glue
  logic   accept;
  logic   take;
  logic   stage_valid;
  stage_t stage_info;
  logic signed [PAIR_W-1:0] stage_pair;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PAIR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PAIR_W-1:0] ram_rdata;

  assign sample_stall = stage_valid & result_valid & result_stall;
  assign accept       = sample_valid & ~sample_stall;
  assign take         = stage_valid & (~result_valid | ~result_stall);

  p2ac_front #(
    .MAX_OUT_COLS (MAX_OUT_COLS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .take        (take),
    .sample      (sample),
    .frame_start (frame_start),
    .out_cols    (out_cols),
    .out_rows    (out_rows),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .stage_valid (stage_valid),
    .stage_info  (stage_info),
    .stage_pair  (stage_pair)
  );

  // line buffer of upper pair sums
  p2ac_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (CLAMP_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  p2ac_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .result_stall  (result_stall),
    .stage_info    (stage_info),
    .stage_pair    (stage_pair),
    .upper_pair    (ram_rdata),
    .high_thr      (high_thr),
    .crit_thr      (crit_thr),
    .result_valid  (result_valid),
    .average_q2    (average_q2),
    .level_class   (level_class),
    .block_col     (block_col),
    .block_row     (block_row),
    .last_of_frame (last_of_frame)
  );

endmodule

@@ design/p2ac_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module p2ac_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/p2ac_front.sv @@
// Front stage: raster position tracking, horizontal pair sums, line buffer
// access and the stage register ahead of the output. Uses p2ac_pkg.
module p2ac_front #(
  parameter int MAX_OUT_COLS = 256,
  parameter int SAMPLE_BITS  = 12,
  localparam int CLAMP_COLS  = (MAX_OUT_COLS < 511) ? MAX_OUT_COLS : 511,
  localparam int ADDR_W      = (CLAMP_COLS > 1) ? $clog2(CLAMP_COLS) : 1,
  localparam int PAIR_W      = SAMPLE_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          take,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          frame_start,
  input  logic [p2ac_pkg::SIZE_W-1:0]   out_cols,
  input  logic [p2ac_pkg::SIZE_W-1:0]   out_rows,
  output logic                          ram_we,
  output logic [ADDR_W-1:0]             ram_waddr,
  output logic [PAIR_W-1:0]             ram_wdata,
  output logic                          ram_re,
  output logic [ADDR_W-1:0]             ram_raddr,
  output logic                          stage_valid,
  output p2ac_pkg::stage_t              stage_info,
  output logic signed [PAIR_W-1:0]      stage_pair
);
  import p2ac_pkg::*;

  localparam int COL_W = $clog2(2 * CLAMP_COLS);
  localparam int CNT_W = COL_W + 1;

  logic [COL_W-1:0]              column_position;
  logic [COL_W-1:0]              column_position_next;
  logic [ROW_W-1:0]              row_position;
  logic [ROW_W-1:0]              row_position_next;
  logic signed [SAMPLE_BITS-1:0] pair_partial_sum;

  logic [SIZE_W-1:0] cols_sat;
  logic [SIZE_W-1:0] rows_sat;
  logic [CNT_W-1:0]  cols;
  logic [CNT_W-1:0]  width;
  logic [CNT_W-1:0]  col_cur;
  logic [CNT_W-1:0]  col_inc;
  logic [CNT_W-1:0]  bc;
  logic [ROW_W:0]    height;
  logic [ROW_W:0]    row_cur;
  logic [ROW_W:0]    row_inc;
  logic [ROW_W:0]    br;
  logic              emit;
  logic              last;
  logic signed [PAIR_W-1:0] pair;

  always_comb begin
    // sizes saturate into 1..max
    if (out_cols == '0) begin
      cols_sat = SIZE_W'(1);
    end else if (out_cols > SIZE_W'(CLAMP_COLS)) begin
      cols_sat = SIZE_W'(CLAMP_COLS);
    end else begin
      cols_sat = out_cols;
    end
    if (out_rows == '0) begin
      rows_sat = SIZE_W'(1);
    end else if (out_rows > SIZE_W'(MAX_OUT_ROWS)) begin
      rows_sat = SIZE_W'(MAX_OUT_ROWS);
    end else begin
      rows_sat = out_rows;
    end
    cols   = CNT_W'(cols_sat);
    width  = cols << 1;
    height = {1'b0, rows_sat} << 1;

    // current position, after frame restart and out-of-range wrap
    col_cur = frame_start ? '0 : CNT_W'(column_position);
    if (col_cur >= width) begin
      col_cur = '0;
    end
    row_cur = frame_start ? '0 : {1'b0, row_position};
    if (row_cur >= height) begin
      row_cur = '0;
    end

    bc = col_cur >> 1;
    br = row_cur >> 1;

    // advance
    col_inc = col_cur + CNT_W'(1);
    row_inc = row_cur;
    if (col_inc >= width) begin
      col_inc = '0;
      row_inc = row_cur + (ROW_W + 1)'(1);
      if (row_inc >= height) begin
        row_inc = '0;
      end
    end
    column_position_next = COL_W'(col_inc);
    row_position_next    = ROW_W'(row_inc);

    pair = PAIR_W'(pair_partial_sum) + PAIR_W'(sample);
    emit = col_cur[0] & row_cur[0];
    last = (bc == cols - CNT_W'(1)) && (br == {1'b0, rows_sat} - (ROW_W + 1)'(1));
  end

  // upper row of a block stores its pair sum, lower row fetches it
  assign ram_we    = accept & col_cur[0] & ~row_cur[0];
  assign ram_waddr = ADDR_W'(bc);
  assign ram_wdata = pair;
  assign ram_re    = accept & emit;
  assign ram_raddr = ADDR_W'(bc);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position  <= '0;
      row_position     <= '0;
      pair_partial_sum <= '0;
      stage_valid      <= 1'b0;
    end else if (accept) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
      if (!col_cur[0]) begin
        pair_partial_sum <= sample;
      end
      stage_valid <= emit;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_info.last <= last;
      stage_info.col  <= 8'(bc);
      stage_info.row  <= 8'(br);
      stage_pair      <= pair;
    end
  end

endmodule

@@ design/p2ac_back.sv @@
// Back stage: block sum, threshold classification and the result register.
// Uses p2ac_pkg.
module p2ac_back #(
  parameter int SAMPLE_BITS = 12,
  localparam int PAIR_W     = SAMPLE_BITS + 1,
  localparam int AVG_W      = SAMPLE_BITS + 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic                              result_stall,
  input  p2ac_pkg::stage_t                  stage_info,
  input  logic signed [PAIR_W-1:0]          stage_pair,
  input  logic [PAIR_W-1:0]                 upper_pair,
  input  logic signed [p2ac_pkg::THR_W-1:0] high_thr,
  input  logic signed [p2ac_pkg::THR_W-1:0] crit_thr,
  output logic                              result_valid,
  output logic signed [AVG_W-1:0]           average_q2,
  output logic [1:0]                        level_class,
  output logic [7:0]                        block_col,
  output logic [7:0]                        block_row,
  output logic                              last_of_frame
);
  import p2ac_pkg::*;

  localparam int CMP_W = (AVG_W > THR_W) ? AVG_W : THR_W;

  logic signed [PAIR_W-1:0] upper_s;
  logic signed [AVG_W-1:0]  avg;
  logic signed [CMP_W-1:0]  avg_c;
  logic signed [CMP_W-1:0]  high_c;
  logic signed [CMP_W-1:0]  crit_c;
  level_t                   level;

  always_comb begin
    upper_s = signed'(upper_pair);
    avg     = AVG_W'(upper_s) + AVG_W'(stage_pair);
    avg_c   = CMP_W'(avg);
    high_c  = CMP_W'(high_thr);
    crit_c  = CMP_W'(crit_thr);
    priority if (avg_c <= high_c) begin
      level = LEVEL_NORMAL;
    end else if (avg_c <= crit_c) begin
      level = LEVEL_HIGH;
    end else begin
      level = LEVEL_CRITICAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      average_q2    <= avg;
      level_class   <= level;
      block_col     <= stage_info.col;
      block_row     <= stage_info.row;
      last_of_frame <= stage_info.last;
    end
  end

endmodule

@@ design/p2ac_checker.sv @@
// Port-level checks for the 2x2 average pooling classifier, bound to the top.
// Uses p2ac_pkg; depends on pool_2x2_average_classify.
module p2ac_checker #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   sample_valid,
  input logic                   sample_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [SAMPLE_BITS+1:0] average_q2,
  input logic [1:0]             level_class,
  input logic [7:0]             block_col,
  input logic [7:0]             block_row,
  input logic                   last_of_frame
);
  import p2ac_pkg::*;

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(average_q2)
      && $stable(level_class) && $stable(block_col) && $stable(block_row)
      && $stable(last_of_frame))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // input backs up only when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("input stalled without output backpressure");

  // a fresh result follows an accepted request, through the stage and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_valid && !sample_stall, 2))
    else $error("result without a request two cycles before");

  // class code never outside its three levels
  a_class_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> level_class == LEVEL_NORMAL || level_class == LEVEL_HIGH
      || level_class == LEVEL_CRITICAL)
    else $error("bad level class");

endmodule

bind pool_2x2_average_classify p2ac_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_p2ac_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample_valid),
  .sample_stall  (sample_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .average_q2    (average_q2),
  .level_class   (level_class),
  .block_col     (block_col),
  .block_row     (block_row),
  .last_of_frame (last_of_frame)
);
